// ===== rtl/core/rat_pkg.sv =====
`timescale 1ns / 1ps
package rat_pkg;

  localparam int SliceW   = 9;
  localparam int AngleW   = 17;
  localparam int RadW     = 16;
  localparam int ColorW   = 32;
  localparam int PosW     = 16;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  localparam int FullTurn    = 46080;
  localparam int HalfTurn    = 23040;
  localparam int QuarterTurn = 11520;
  localparam int UnitRadius  = 32768;
  localparam int PosLimit    = 16384;

  localparam int CordicSteps = 16;
  localparam int DivSteps    = 8;
  localparam int XyW         = 34;
  localparam int ZW          = 24;
  localparam int NumW        = 26;
  localparam int TW          = 17;
  localparam int ProdPW      = XyW + 18;

  localparam logic signed [XyW-1:0] CordicGain = 34'sd652032875;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_ANGLE       = 4'd0,
    CFG_END_ANGLE         = 4'd1,
    CFG_INNER_RADIUS      = 4'd2,
    CFG_DRAW_MODE         = 4'd3,
    CFG_INNER_START_COLOR = 4'd4,
    CFG_INNER_END_COLOR   = 4'd5,
    CFG_OUTER_START_COLOR = 4'd6,
    CFG_OUTER_END_COLOR   = 4'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_FAN   = 2'd0,
    KIND_STRIP = 2'd1,
    KIND_LINE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [AngleW-1:0] start_angle;
    logic signed [AngleW-1:0] end_angle;
    logic [RadW-1:0]          inner_radius;
    logic                     draw_mode;
    logic [ColorW-1:0]        inner_start_color;
    logic [ColorW-1:0]        inner_end_color;
    logic [ColorW-1:0]        outer_start_color;
    logic [ColorW-1:0]        outer_end_color;
  } rat_cfg_t;

  // per-slice control that rides along the pipeline
  typedef struct packed {
    kind_t             kind;
    logic [1:0]        n_res;
    logic              last;
    logic              blend_in;
    logic              blend_out;
    logic [ColorW-1:0] col_in;
    logic [ColorW-1:0] col_out;
  } rat_meta_t;

  typedef struct packed {
    rat_meta_t                meta;
    logic signed [XyW-1:0]    x;
    logic signed [XyW-1:0]    y;
    logic signed [ZW-1:0]     z;
    logic                     neg;
    logic [TW-1:0]            t;
    logic [3:0][NumW-1:0]     rem_in;
    logic [3:0][NumW-1:0]     rem_out;
    logic [3:0][7:0]          q_in;
    logic [3:0][7:0]          q_out;
  } rat_cd_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_z;
    logic [ColorW-1:0]      color;
    kind_t                  kind;
    logic                   last;
  } rat_vtx_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 24'sd2949120;
      4'd1:    v = 24'sd1740967;
      4'd2:    v = 24'sd919879;
      4'd3:    v = 24'sd466945;
      4'd4:    v = 24'sd234379;
      4'd5:    v = 24'sd117304;
      4'd6:    v = 24'sd58666;
      4'd7:    v = 24'sd29335;
      4'd8:    v = 24'sd14668;
      4'd9:    v = 24'sd7334;
      4'd10:   v = 24'sd3667;
      4'd11:   v = 24'sd1833;
      4'd12:   v = 24'sd917;
      4'd13:   v = 24'sd458;
      4'd14:   v = 24'sd229;
      default: v = 24'sd115;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/rat_in_if.sv =====
`timescale 1ns / 1ps
interface rat_in_if;
  logic                         valid;
  logic                         ready;
  logic [rat_pkg::SliceW-1:0]   slice_index;
  modport source (output valid, output slice_index, input ready);
  modport sink (input valid, input slice_index, output ready);
endinterface

// ===== rtl/core/rat_out_if.sv =====
`timescale 1ns / 1ps
interface rat_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rat_pkg::PosW-1:0]  pos_x;
  logic signed [rat_pkg::PosW-1:0]  pos_z;
  logic [7:0]                       red;
  logic [7:0]                       green;
  logic [7:0]                       blue;
  logic [7:0]                       alpha;
  logic [1:0]                       primitive_kind;
  logic                             last_vertex;
  modport source (output valid, output pos_x, output pos_z, output red, output green,
                  output blue, output alpha, output primitive_kind, output last_vertex,
                  input ready);
  modport sink (input valid, input pos_x, input pos_z, input red, input green,
                input blue, input alpha, input primitive_kind, input last_vertex,
                output ready);
endinterface

// ===== rtl/core/rat_cfg_if.sv =====
`timescale 1ns / 1ps
interface rat_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rat_pkg::CfgIdxW-1:0]   index;
  logic [rat_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rat_cfg_regs.sv =====
`timescale 1ns / 1ps
module rat_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  rat_cfg_if.sink          cfg_ch,
  output rat_pkg::rat_cfg_t cfg
);

  rat_pkg::rat_cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (rat_pkg::cfg_idx_t'(cfg_ch.index))
        rat_pkg::CFG_START_ANGLE:       cfg_nxt.start_angle = cfg_ch.data[16:0];
        rat_pkg::CFG_END_ANGLE:         cfg_nxt.end_angle = cfg_ch.data[16:0];
        rat_pkg::CFG_INNER_RADIUS:      cfg_nxt.inner_radius = cfg_ch.data[15:0];
        rat_pkg::CFG_DRAW_MODE:         cfg_nxt.draw_mode = cfg_ch.data[0];
        rat_pkg::CFG_INNER_START_COLOR: cfg_nxt.inner_start_color = cfg_ch.data;
        rat_pkg::CFG_INNER_END_COLOR:   cfg_nxt.inner_end_color = cfg_ch.data;
        rat_pkg::CFG_OUTER_START_COLOR: cfg_nxt.outer_start_color = cfg_ch.data;
        rat_pkg::CFG_OUTER_END_COLOR:   cfg_nxt.outer_end_color = cfg_ch.data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_angle       <= '0;
      cfg_r.end_angle         <= 17'(rat_pkg::FullTurn);
      cfg_r.inner_radius      <= '0;
      cfg_r.draw_mode         <= 1'b0;
      cfg_r.inner_start_color <= '1;
      cfg_r.inner_end_color   <= '1;
      cfg_r.outer_start_color <= '1;
      cfg_r.outer_end_color   <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/rat_front.sv =====
`timescale 1ns / 1ps
module rat_front #(
  parameter int MAX_SLICES = 512,
  parameter int ANGLE_STEP = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rat_pkg::SliceW-1:0]  slice_index,
  input  rat_pkg::rat_cfg_t           cfg,
  output logic                        out_valid,
  output rat_pkg::rat_cd_t            out_item
);

  localparam int ProdW = rat_pkg::SliceW + $clog2(ANGLE_STEP + 1);
  localparam int AngW  = ((ProdW > rat_pkg::AngleW) ? ProdW : rat_pkg::AngleW) + 2;
  localparam int KW    = (($clog2(MAX_SLICES + 1) > rat_pkg::SliceW) ?
                          $clog2(MAX_SLICES + 1) : rat_pkg::SliceW) + 1;

  // stage 1: slice angle
  logic                              v1_r;
  logic [rat_pkg::SliceW-1:0]        k1_r;
  logic signed [AngW-1:0]            ang1_r;
  logic                              ok1_r;
  logic [rat_pkg::TW-1:0]            d1_r;
  logic [ProdW-1:0]                  prod;
  logic signed [AngW-1:0]            ang_nxt;

  assign prod    = ProdW'(slice_index) * ProdW'(ANGLE_STEP);
  assign ang_nxt = AngW'(cfg.start_angle) + AngW'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_r   <= slice_index;
      ang1_r <= ang_nxt;
      ok1_r  <= KW'(slice_index) < KW'(MAX_SLICES);
      d1_r   <= rat_pkg::TW'(prod);
    end
  end

  // stage 2: classify the slice
  logic                              v2_r;
  rat_pkg::rat_meta_t                meta2_r, meta2_nxt;
  logic signed [rat_pkg::AngleW-1:0] tang2_r, tang2_nxt;
  logic [rat_pkg::TW-1:0]            d2_r;
  logic [rat_pkg::TW-1:0]            t2_r;
  logic signed [AngW-1:0]            end_x;
  logic signed [AngW-1:0]            prev;
  logic signed [rat_pkg::AngleW:0]   t_full;
  logic                              below;
  logic                              closing;
  rat_pkg::kind_t                    kind;
  logic [1:0]                        n_base;

  always_comb begin
    end_x   = AngW'(cfg.end_angle);
    prev    = ang1_r - AngW'(ANGLE_STEP);
    below   = ang1_r < end_x;
    closing = !below && ((k1_r == '0) || (prev < end_x));
    t_full  = (rat_pkg::AngleW+1)'(cfg.end_angle) - (rat_pkg::AngleW+1)'(cfg.start_angle);
    if (cfg.draw_mode) kind = rat_pkg::KIND_LINE;
    else if (cfg.inner_radius == '0) kind = rat_pkg::KIND_FAN;
    else kind = rat_pkg::KIND_STRIP;
    if (kind == rat_pkg::KIND_LINE) n_base = 2'd1;
    else if (kind == rat_pkg::KIND_FAN && k1_r != '0) n_base = 2'd1;
    else n_base = 2'd2;

    meta2_nxt.kind      = kind;
    meta2_nxt.n_res     = (ok1_r && (below || closing)) ? n_base : 2'd0;
    meta2_nxt.last      = !below;
    meta2_nxt.blend_in  = below && (kind == rat_pkg::KIND_STRIP);
    meta2_nxt.blend_out = below && (kind != rat_pkg::KIND_LINE);
    meta2_nxt.col_in    = (kind == rat_pkg::KIND_FAN) ? cfg.inner_start_color
                                                      : cfg.inner_end_color;
    meta2_nxt.col_out   = (kind == rat_pkg::KIND_LINE) ? cfg.outer_start_color
                                                       : cfg.outer_end_color;
    tang2_nxt = below ? ang1_r[rat_pkg::AngleW-1:0] : cfg.end_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta2_r <= meta2_nxt;
      tang2_r <= tang2_nxt;
      d2_r    <= d1_r;
      t2_r    <= t_full[rat_pkg::TW-1:0];
    end
  end

  // stage 3: angle reduction and blend numerators
  logic                   v3_r;
  rat_pkg::rat_cd_t       it3_r, it3_nxt;
  logic signed [18:0]     rx;
  logic signed [18:0]     rm;
  logic [rat_pkg::TW-1:0] tmd;
  logic [7:0]             ca, cb;

  always_comb begin
    rx = 19'(tang2_r) + 19'(2 * rat_pkg::FullTurn);
    if (rx >= 19'(3 * rat_pkg::FullTurn)) rm = rx - 19'(3 * rat_pkg::FullTurn);
    else if (rx >= 19'(2 * rat_pkg::FullTurn)) rm = rx - 19'(2 * rat_pkg::FullTurn);
    else if (rx >= 19'(rat_pkg::FullTurn)) rm = rx - 19'(rat_pkg::FullTurn);
    else rm = rx;
    if (rm > 19'(rat_pkg::HalfTurn)) rm = rm - 19'(rat_pkg::FullTurn);
    it3_nxt.neg = 1'b0;
    if (rm > 19'(rat_pkg::QuarterTurn)) begin
      rm = rm - 19'(rat_pkg::HalfTurn);
      it3_nxt.neg = 1'b1;
    end else if (rm < -19'(rat_pkg::QuarterTurn)) begin
      rm = rm + 19'(rat_pkg::HalfTurn);
      it3_nxt.neg = 1'b1;
    end
    it3_nxt.meta = meta2_r;
    it3_nxt.x    = rat_pkg::CordicGain;
    it3_nxt.y    = '0;
    it3_nxt.z    = rat_pkg::ZW'(rm) <<< 9;
    it3_nxt.t    = t2_r;
    it3_nxt.q_in  = '0;
    it3_nxt.q_out = '0;
    tmd = t2_r - d2_r;
    ca  = '0;
    cb  = '0;
    for (int c = 0; c < 4; c++) begin
      ca = cfg.outer_start_color[8*c +: 8];
      cb = cfg.outer_end_color[8*c +: 8];
      it3_nxt.rem_out[c] = rat_pkg::NumW'(ca) * rat_pkg::NumW'(tmd)
                         + rat_pkg::NumW'(cb) * rat_pkg::NumW'(d2_r)
                         + rat_pkg::NumW'(t2_r >> 1);
      ca = cfg.inner_start_color[8*c +: 8];
      cb = cfg.inner_end_color[8*c +: 8];
      it3_nxt.rem_in[c] = rat_pkg::NumW'(ca) * rat_pkg::NumW'(tmd)
                        + rat_pkg::NumW'(cb) * rat_pkg::NumW'(d2_r)
                        + rat_pkg::NumW'(t2_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it3_r <= it3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = it3_r;

endmodule

// ===== rtl/core/rat_cordic_div.sv =====
`timescale 1ns / 1ps
module rat_cordic_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  rat_pkg::rat_cd_t in_item,
  output logic             out_valid,
  output rat_pkg::rat_cd_t out_item
);

  // one CORDIC rotation per stage; the first stages also retire one quotient bit
  function automatic rat_pkg::rat_cd_t cd_step(input rat_pkg::rat_cd_t s, input int j);
    rat_pkg::rat_cd_t            r;
    logic signed [rat_pkg::XyW-1:0] dx, dy;
    logic [rat_pkg::NumW-1:0]    dv;
    int                          sh;
    r  = s;
    dx = s.y >>> j;
    dy = s.x >>> j;
    if (s.z >= 0) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - rat_pkg::atan_q16(4'(j));
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + rat_pkg::atan_q16(4'(j));
    end
    if (j < rat_pkg::DivSteps) begin
      sh = rat_pkg::DivSteps - 1 - j;
      dv = rat_pkg::NumW'(s.t) << sh;
      for (int c = 0; c < 4; c++) begin
        if (s.rem_in[c] >= dv) begin
          r.rem_in[c]   = s.rem_in[c] - dv;
          r.q_in[c][sh] = 1'b1;
        end
        if (s.rem_out[c] >= dv) begin
          r.rem_out[c]   = s.rem_out[c] - dv;
          r.q_out[c][sh] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  logic             v_r  [rat_pkg::CordicSteps];
  rat_pkg::rat_cd_t st_r [rat_pkg::CordicSteps];

  for (genvar j = 0; j < rat_pkg::CordicSteps; j++) begin : g_stage
    logic             v_prev;
    rat_pkg::rat_cd_t st_prev;
    if (j == 0) begin : g_head
      assign v_prev  = in_valid;
      assign st_prev = in_item;
    end else begin : g_body
      assign v_prev  = v_r[j-1];
      assign st_prev = st_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= cd_step(st_prev, j);
      end
    end
  end

  assign out_valid = v_r[rat_pkg::CordicSteps-1];
  assign out_item  = st_r[rat_pkg::CordicSteps-1];

endmodule

// ===== rtl/core/rat_vertex_out.sv =====
`timescale 1ns / 1ps
module rat_vertex_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rat_pkg::rat_cd_t  in_item,
  input  rat_pkg::rat_cfg_t cfg,
  output logic              adv,
  rat_out_if.source         out_ch
);

  localparam int PW = rat_pkg::ProdPW;

  function automatic logic signed [rat_pkg::PosW-1:0] sat_pos(input logic signed [PW-1:0] v);
    logic signed [rat_pkg::PosW-1:0] r;
    if (v > PW'(rat_pkg::PosLimit)) r = rat_pkg::PosW'(rat_pkg::PosLimit);
    else if (v < -PW'(rat_pkg::PosLimit)) r = -rat_pkg::PosW'(rat_pkg::PosLimit);
    else r = v[rat_pkg::PosW-1:0];
    return r;
  endfunction

  // stage B1: sign fix, outer scale, inner multiply, color pick
  logic                            vb1_r;
  rat_pkg::rat_meta_t              mb1_r;
  logic signed [rat_pkg::PosW-1:0] ox_r, oz_r;
  logic signed [PW-1:0]            px_r, pz_r;
  logic [rat_pkg::ColorW-1:0]      ci_r, co_r;
  logic signed [rat_pkg::XyW-1:0]  xs, ys;
  logic signed [rat_pkg::XyW-1:0]  oxw, ozw;
  logic [16:0]                     irc;
  logic signed [PW-1:0]            ir_s;

  always_comb begin
    xs   = in_item.neg ? -in_item.x : in_item.x;
    ys   = in_item.neg ? -in_item.y : in_item.y;
    oxw  = (xs + rat_pkg::XyW'(32768)) >>> 16;
    ozw  = (ys + rat_pkg::XyW'(32768)) >>> 16;
    irc  = (cfg.inner_radius > 16'(rat_pkg::UnitRadius)) ? 17'(rat_pkg::UnitRadius)
                                                         : 17'(cfg.inner_radius);
    ir_s = PW'(signed'({1'b0, irc}));
  end

  // stage B2
  logic                            vb2_r;
  rat_pkg::rat_vtx_t               vin_r, vout_r;
  logic [1:0]                      nb2_r;
  logic signed [PW-1:0]            ixw, izw;
  rat_pkg::rat_vtx_t               vin_nxt, vout_nxt;

  always_comb begin
    ixw = (px_r + PW'(64'sd1073741824)) >>> 31;
    izw = (pz_r + PW'(64'sd1073741824)) >>> 31;
    vin_nxt.pos_x  = sat_pos(ixw);
    vin_nxt.pos_z  = sat_pos(izw);
    vin_nxt.color  = ci_r;
    vin_nxt.kind   = mb1_r.kind;
    vin_nxt.last   = 1'b0;
    vout_nxt.pos_x = ox_r;
    vout_nxt.pos_z = oz_r;
    vout_nxt.color = co_r;
    vout_nxt.kind  = mb1_r.kind;
    vout_nxt.last  = mb1_r.last;
  end

  // output buffer: up to two vertices of one slice
  rat_pkg::rat_vtx_t r0_r, r0_nxt, r1_r, r1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              can_take;

  assign can_take = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign adv      = !vb2_r || can_take;

  always_comb begin
    cnt_nxt = cnt_r;
    r0_nxt  = r0_r;
    r1_nxt  = r1_r;
    if ((cnt_r != 2'd0) && out_ch.ready) begin
      if (cnt_r == 2'd2) begin
        r0_nxt  = r1_r;
        cnt_nxt = 2'd1;
      end else begin
        cnt_nxt = 2'd0;
      end
    end
    if (vb2_r && can_take) begin
      cnt_nxt = nb2_r;
      r0_nxt  = (nb2_r == 2'd2) ? vin_r : vout_r;
      r1_nxt  = vout_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb1_r <= 1'b0;
      vb2_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (adv) begin
        vb1_r <= in_valid;
        vb2_r <= vb1_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mb1_r  <= in_item.meta;
      ox_r   <= sat_pos(PW'(oxw));
      oz_r   <= sat_pos(PW'(ozw));
      px_r   <= PW'(xs) * ir_s;
      pz_r   <= PW'(ys) * ir_s;
      ci_r   <= in_item.meta.blend_in ? in_item.q_in : in_item.meta.col_in;
      co_r   <= in_item.meta.blend_out ? in_item.q_out : in_item.meta.col_out;
      vin_r  <= vin_nxt;
      vout_r <= vout_nxt;
      nb2_r  <= mb1_r.n_res;
    end
    r0_r <= r0_nxt;
    r1_r <= r1_nxt;
  end

  assign out_ch.valid          = cnt_r != 2'd0;
  assign out_ch.pos_x          = r0_r.pos_x;
  assign out_ch.pos_z          = r0_r.pos_z;
  assign out_ch.red            = r0_r.color[31:24];
  assign out_ch.green          = r0_r.color[23:16];
  assign out_ch.blue           = r0_r.color[15:8];
  assign out_ch.alpha          = r0_r.color[7:0];
  assign out_ch.primitive_kind = r0_r.kind;
  assign out_ch.last_vertex    = r0_r.last;

endmodule

// ===== rtl/core/ring_arc_tessellator.sv =====
`timescale 1ns / 1ps
// Ring / arc vertex generator.
// in_ch  : one item per slice index k; the slice angle is start + k*ANGLE_STEP
//          (Q.7 degrees). Fully pipelined, a new item can enter every cycle
//          while out_ch does not stall the pipe.
// out_ch : zero, one or two vertex items per slice (position Q2.14, RGBA8,
//          primitive kind, last flag). Slices with two vertices hold the
//          output until both are sent, so with out_ch ready the sustained
//          rate is one slice per cycle for one-vertex slices, and a two-vertex
//          slice holds off the next one; the single output port sets this.
// cfg_ch : register writes, always ready; write only while the pipe is empty.
// Path   : a slice passes 3 setup stages, 16 CORDIC/divider stages,
//          2 scaling stages and 1 output buffer on its way to out_ch.
// Stall  : when out_ch is not taken the whole pipe freezes once its last
//          stage holds a slice; bubbles keep moving, nothing is dropped.
// Reset  : rst_n low (sync) empties the pipe and restores register defaults
//          (full 360 degree fan, white).
module ring_arc_tessellator #(
  parameter int MAX_SLICES = 512,
  parameter int ANGLE_STEP = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  rat_in_if.sink    in_ch,
  rat_out_if.source out_ch,
  rat_cfg_if.sink   cfg_ch
);

  rat_pkg::rat_cfg_t cfg;
  logic              adv;        // global pipeline advance
  logic              fr_valid;
  rat_pkg::rat_cd_t  fr_item;
  logic              cd_valid;
  rat_pkg::rat_cd_t  cd_item;

  assign in_ch.ready = adv;

  rat_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // angle, slice classification, angle folding, blend numerators
  rat_front #(
    .MAX_SLICES (MAX_SLICES),
    .ANGLE_STEP (ANGLE_STEP)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (in_ch.valid),
    .slice_index (in_ch.slice_index),
    .cfg         (cfg),
    .out_valid   (fr_valid),
    .out_item    (fr_item)
  );

  // sine/cosine and the color divides share the same stage chain
  rat_cordic_div u_cd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_item   (fr_item),
    .out_valid (cd_valid),
    .out_item  (cd_item)
  );

  rat_vertex_out u_vout (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (cd_valid),
    .in_item  (cd_item),
    .cfg      (cfg),
    .adv      (adv),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/core/rat_checker.sv =====
`timescale 1ns / 1ps
module rat_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [rat_pkg::PosW-1:0] pos_x,
  input logic signed [rat_pkg::PosW-1:0] pos_z,
  input logic [1:0]                      primitive_kind,
  input logic                            last_vertex
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_z)
      && $stable(primitive_kind) && $stable(last_vertex))
    else $error("stalled vertex changed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> primitive_kind != 2'd3)
    else $error("bad primitive kind");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pos_x >= -16'sd16384 && pos_x <= 16'sd16384
      && pos_z >= -16'sd16384 && pos_z <= 16'sd16384)
    else $error("position out of range");

endmodule

bind ring_arc_tessellator rat_checker u_rat_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .pos_x          (out_ch.pos_x),
  .pos_z          (out_ch.pos_z),
  .primitive_kind (out_ch.primitive_kind),
  .last_vertex    (out_ch.last_vertex)
);
